@@ rtl/ifus_pkg.sv @@
// Shared types, constants and helper functions for the isothermal flow step unit.
// Holds the input and result word structs and the multiplier request struct.
// No dependencies.
package ifus_pkg;

  // default fraction bits of values and gains
  localparam int VFB_DEF = 20;
  localparam int GFB_DEF = 28;

  // field and datapath widths
  localparam int MOM_W      = 32;
  localparam int DEN_W      = 31;
  localparam int ACC_W      = 68;
  localparam int PROD_W     = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADVECT_GAIN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_GAIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VISCOUS_GAIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_FROZEN = 4'd3;

  // register reset values
  localparam logic [31:0] ADVECT_GAIN_RST   = 32'd74565;
  localparam logic [31:0] PRESSURE_GAIN_RST = 32'd92945777;
  localparam logic [31:0] VISCOUS_GAIN_RST  = 32'd0;

  // saturation limits
  localparam logic [31:0]      S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0]      S32_MIN = 32'h8000_0000;
  localparam logic [DEN_W-1:0] D31_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic signed [MOM_W-1:0] momentum;
    logic [DEN_W-1:0]        density;
    logic                    first_cell;
    logic                    last_cell;
  } in_t;

  typedef struct packed {
    logic signed [MOM_W-1:0] new_momentum;
    logic [DEN_W-1:0]        new_density;
    logic                    grid_end;
    logic                    run_end;
  } out_t;

  typedef struct packed {
    logic        start;
    logic        use_gain;
    logic        neg;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // saturate a wide signed value to 32 signed bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:31]) || (~|v[ACC_W-1:31])) begin
      return $signed(v[31:0]);
    end
    return v[ACC_W-1] ? $signed(S32_MIN) : $signed(S32_MAX);
  endfunction

  // magnitude of a wide signed value, known to stay within 32 bits
  function automatic logic [31:0] mag32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] a;
    a = v[ACC_W-1] ? -v : v;
    return a[31:0];
  endfunction

  // sign extend a 32-bit value to the accumulator width
  function automatic logic signed [ACC_W-1:0] sx32(input logic signed [31:0] v);
    return ACC_W'(v);
  endfunction

  // zero extend a density to the accumulator width
  function automatic logic signed [ACC_W-1:0] zx31(input logic [DEN_W-1:0] v);
    return $signed({{(ACC_W-DEN_W){1'b0}}, v});
  endfunction

endpackage

@@ rtl/isothermal_flow_upwind_step_unit.sv @@
// Isothermal 1-D flow, one upwind explicit Euler step over a streamed cell window.
// The first two cells of a window need only the serial divider; every later cell then adds
// 5 (density frozen) or 8 serial products on the shared multiplier. Throughput: one word at
// a time, set by the divider and shared multiplier.
// Reset: synchronous, clears the window, cell count and result buffer, loads gain defaults.
module isothermal_flow_upwind_step_unit
  import ifus_pkg::*;
#(
  parameter int VALUE_FRAC_BITS = VFB_DEF,
  parameter int GAIN_FRAC_BITS  = GFB_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MUL_GO, S_MUL_WAIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    P_FC, P_FO, P_ADV, P_PRES, P_VISC, P_A, P_B, P_T
  } step_t;

  state_t state_r;
  step_t  step_r;

  // configuration
  logic [31:0] adv_gain_r;
  logic [31:0] pres_gain_r;
  logic [31:0] visc_gain_r;
  logic        frozen_r;

  // cell window
  logic signed [31:0] wm_r [2];
  logic [DEN_W-1:0]   wd_r [2];
  logic signed [31:0] wu_r [2];
  logic [DEN_W-1:0]   edge_d_r;
  logic [1:0]         seen_r;

  // arriving cell
  logic signed [31:0] im_r;
  logic [DEN_W-1:0]   id_r;
  logic               ilast_r;
  logic [1:0]         c_r;
  logic signed [31:0] u_r;

  // interior intermediates
  logic signed [31:0]      fc_r;
  logic signed [31:0]      df_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0]      pa_r;
  logic signed [31:0]      s_r;
  logic [DEN_W-1:0]        dn_r;

  // result buffer
  out_t       ob_r [2];
  logic [1:0] ob_cnt_r;

  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] u_calc;

  mul_req_t                mul_req;
  logic                    mul_done;
  logic signed [PROD_W-1:0] mul_res;

  logic                    fwd;
  logic signed [ACC_W-1:0] dd_pres, dd_fwd, dd_bwd, du, lap;
  logic signed [ACC_W-1:0] op_x, op_y;
  logic                    op_gain;
  logic signed [ACC_W-1:0] res_ext;
  logic signed [31:0]      res_sat;
  logic signed [31:0]      df_calc;
  logic signed [31:0]      s_calc;
  logic signed [ACC_W-1:0] dn_diff;
  logic [DEN_W-1:0]        dn_calc;
  logic signed [31:0]      mn;
  out_t                    r0, r1;
  logic [1:0]              n_res;

  ifus_div #(
    .VALUE_FRAC_BITS(VALUE_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIV_GO),
    .num   (mag32(sx32(im_r))),
    .den   (id_r),
    .done  (div_done),
    .quo   (div_q)
  );

  ifus_mul #(
    .VALUE_FRAC_BITS(VALUE_FRAC_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .res   (mul_res)
  );

  // sign the velocity; zero momentum gives zero
  always_comb begin
    if (im_r == 32'sd0) begin
      u_calc = '0;
    end else if (im_r[31]) begin
      u_calc = ~div_q + 32'd1;
    end else begin
      u_calc = div_q[31] ? S32_MAX : div_q;
    end
  end

  // differences around the centre cell
  assign fwd     = ~wm_r[1][31];
  assign dd_pres = zx31(id_r) - zx31(wd_r[0]);
  assign dd_fwd  = zx31(wd_r[1]) - zx31(wd_r[0]);
  assign dd_bwd  = zx31(id_r) - zx31(wd_r[1]);
  assign du      = sx32(sat32(fwd ? (sx32(wu_r[1]) - sx32(wu_r[0]))
                                  : (sx32(u_r) - sx32(wu_r[1]))));
  assign lap     = sx32(sat32(sx32(wu_r[0]) - (sx32(wu_r[1]) <<< 1) + sx32(u_r)));

  // select multiplier operands for the current step
  always_comb begin
    op_gain = 1'b0;
    case (step_r)
      P_FC: begin
        op_x = sx32(wm_r[1]);
        op_y = sx32(wu_r[1]);
      end
      P_FO: begin
        op_x = fwd ? sx32(wm_r[0]) : sx32(im_r);
        op_y = fwd ? sx32(wu_r[0]) : sx32(u_r);
      end
      P_ADV: begin
        op_x    = $signed({{(ACC_W-32){1'b0}}, adv_gain_r});
        op_y    = sx32(df_r);
        op_gain = 1'b1;
      end
      P_PRES: begin
        op_x    = $signed({{(ACC_W-32){1'b0}}, pres_gain_r});
        op_y    = dd_pres;
        op_gain = 1'b1;
      end
      P_VISC: begin
        op_x    = $signed({{(ACC_W-32){1'b0}}, visc_gain_r});
        op_y    = lap;
        op_gain = 1'b1;
      end
      P_A: begin
        op_x = sx32(wu_r[1]);
        op_y = fwd ? dd_fwd : dd_bwd;
      end
      P_B: begin
        op_x = zx31(wd_r[1]);
        op_y = du;
      end
      P_T: begin
        op_x    = $signed({{(ACC_W-32){1'b0}}, adv_gain_r});
        op_y    = sx32(s_r);
        op_gain = 1'b1;
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  assign mul_req = '{
    start:    (state_r == S_MUL_GO),
    use_gain: op_gain,
    neg:      op_x[ACC_W-1] ^ op_y[ACC_W-1],
    a:        mag32(op_x),
    b:        mag32(op_y)
  };

  // fold the product into the running terms
  assign res_ext = ACC_W'(mul_res);
  assign res_sat = sat32(res_ext);
  assign df_calc = sat32(fwd ? (sx32(fc_r) - sx32(res_sat)) : (sx32(res_sat) - sx32(fc_r)));
  assign s_calc  = sat32(sx32(pa_r) + sx32(res_sat));
  assign dn_diff = zx31(wd_r[1]) - res_ext;

  always_comb begin
    if (dn_diff[ACC_W-1]) begin
      dn_calc = '0;
    end else if (|dn_diff[ACC_W-2:DEN_W]) begin
      dn_calc = D31_MAX;
    end else begin
      dn_calc = dn_diff[DEN_W-1:0];
    end
  end

  assign mn = sat32(acc_r);

  // pick the words this cell releases
  always_comb begin
    r0    = '0;
    r1    = '0;
    n_res = 2'd0;
    case (c_r)
      2'd0: begin
        r0    = '{im_r, id_r, 1'b1, 1'b1};
        n_res = ilast_r ? 2'd1 : 2'd0;
      end
      2'd1: begin
        r0    = '{wm_r[1], edge_d_r, 1'b0, 1'b0};
        r1    = '{im_r, id_r, 1'b1, 1'b1};
        n_res = ilast_r ? 2'd2 : 2'd0;
      end
      default: begin
        if (c_r == 2'd2 && !ilast_r) begin
          r0    = '{mn, edge_d_r, 1'b0, 1'b0};
          r1    = '{mn, dn_r, 1'b0, 1'b1};
          n_res = 2'd2;
        end else begin
          r0    = '{mn, dn_r, 1'b0, ~ilast_r};
          r1    = '{mn, id_r, 1'b1, 1'b1};
          n_res = ilast_r ? 2'd2 : 2'd1;
        end
      end
    endcase
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_gain_r  <= ADVECT_GAIN_RST;
      pres_gain_r <= PRESSURE_GAIN_RST;
      visc_gain_r <= VISCOUS_GAIN_RST;
      frozen_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ADVECT_GAIN:    adv_gain_r  <= cfg_data;
        REG_PRESSURE_GAIN:  pres_gain_r <= cfg_data;
        REG_VISCOUS_GAIN:   visc_gain_r <= cfg_data;
        REG_DENSITY_FROZEN: frozen_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer, window and result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= P_FC;
      seen_r   <= '0;
      ob_cnt_r <= '0;
      edge_d_r <= '0;
      wm_r[0]  <= '0;
      wm_r[1]  <= '0;
      wd_r[0]  <= '0;
      wd_r[1]  <= '0;
      wu_r[0]  <= '0;
      wu_r[1]  <= '0;
    end else begin
      // drop a delivered word
      if (out_valid && out_ready) begin
        ob_r[0]  <= ob_r[1];
        ob_cnt_r <= ob_cnt_r - 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            im_r    <= in_data.momentum;
            id_r    <= in_data.density;
            ilast_r <= in_data.last_cell;
            c_r     <= in_data.first_cell ? 2'd0 : seen_r;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            u_r <= $signed(u_calc);
            if (c_r[1]) begin
              step_r  <= P_FC;
              state_r <= S_MUL_GO;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_MUL_GO: begin
          state_r <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            state_r <= S_MUL_GO;
            case (step_r)
              P_FC: begin
                fc_r   <= res_sat;
                step_r <= P_FO;
              end
              P_FO: begin
                df_r   <= df_calc;
                step_r <= P_ADV;
              end
              P_ADV: begin
                acc_r  <= sx32(wm_r[1]) - res_ext;
                step_r <= P_PRES;
              end
              P_PRES: begin
                acc_r  <= acc_r - res_ext;
                step_r <= P_VISC;
              end
              P_VISC: begin
                acc_r <= acc_r + res_ext;
                if (frozen_r) begin
                  dn_r    <= wd_r[1];
                  state_r <= S_OUT;
                end else begin
                  step_r <= P_A;
                end
              end
              P_A: begin
                pa_r   <= res_sat;
                step_r <= P_B;
              end
              P_B: begin
                s_r    <= s_calc;
                step_r <= P_T;
              end
              P_T: begin
                dn_r    <= dn_calc;
                state_r <= S_OUT;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          // if words are to be loaded, hold until the buffer is free; then load them and advance the window
          if (n_res == 2'd0 || ob_cnt_r == 2'd0) begin
            if (n_res != 2'd0) begin
              ob_r[0]  <= r0;
              ob_r[1]  <= r1;
              ob_cnt_r <= n_res;
            end
            if (c_r == 2'd0) begin
              edge_d_r <= id_r;
            end
            wm_r[0] <= wm_r[1];
            wd_r[0] <= wd_r[1];
            wu_r[0] <= wu_r[1];
            wm_r[1] <= im_r;
            wd_r[1] <= id_r;
            wu_r[1] <= u_r;
            if (ilast_r) begin
              seen_r <= 2'd0;
            end else if (c_r != 2'd3) begin
              seen_r <= c_r + 2'd1;
            end else begin
              seen_r <= 2'd3;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (ob_cnt_r != 2'd0);
  assign out_data  = ob_r[0];

endmodule

@@ rtl/ifus_div.sv @@
// Bit-serial restoring divider for the cell velocity, one quotient bit per cycle.
// Quotient magnitude saturates at 2^31. Depends on ifus_pkg.
module ifus_div
  import ifus_pkg::*;
#(
  parameter int VALUE_FRAC_BITS = VFB_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [31:0]      quo
);

  localparam int NW = 32 + VALUE_FRAC_BITS;
  localparam int CW = $clog2(NW);

  logic [NW-1:0]    dvd_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [32:0]      q_r;
  logic             ovf_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [31:0] trial;
  logic [31:0] trial_sub;
  logic        ge;

  // trial subtract of the shifted remainder
  assign trial     = {rem_r, dvd_r[NW-1]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  // advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= {num, {VALUE_FRAC_BITS{1'b0}}};
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[NW-2:0], 1'b0};
        rem_r <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        q_r   <= {q_r[31:0], ge};
        ovf_r <= ovf_r | q_r[32];
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // clamp the magnitude at 2^31
  always_comb begin
    if (ovf_r || q_r[32] || (q_r[31] && (|q_r[30:0]))) begin
      quo = S32_MIN;
    end else begin
      quo = q_r[31:0];
    end
  end

  assign done = done_r;

endmodule

@@ rtl/ifus_mul.sv @@
// Shared bit-serial multiplier: 32 by 32 magnitudes, one multiplier bit per cycle.
// Shifts the product by the value or gain fraction bits and applies the sign. Uses ifus_pkg.
module ifus_mul
  import ifus_pkg::*;
#(
  parameter int VALUE_FRAC_BITS = VFB_DEF,
  parameter int GAIN_FRAC_BITS  = GFB_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mul_req_t                 req,
  output logic                     done,
  output logic signed [PROD_W-1:0] res
);

  localparam int STEPS = 32;
  localparam int CW    = $clog2(STEPS);

  logic [31:0]   a_r;
  logic [31:0]   hi_r;
  logic [31:0]   lo_r;
  logic          neg_r;
  logic          gain_r;
  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;

  logic [32:0]       sum;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] shifted;

  // add the multiplicand on a set multiplier bit
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : 33'd0);

  // shift-add one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= req.a;
        lo_r   <= req.b;
        hi_r   <= '0;
        neg_r  <= req.neg;
        gain_r <= req.use_gain;
      end else if (busy_r) begin
        hi_r <= sum[32:1];
        lo_r <= {sum[0], lo_r[31:1]};
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // scale and sign the finished product
  assign prod    = {hi_r, lo_r};
  assign shifted = gain_r ? (prod >> GAIN_FRAC_BITS) : (prod >> VALUE_FRAC_BITS);
  assign res     = neg_r ? -$signed(shifted) : $signed(shifted);
  assign done    = done_r;

endmodule
